/* rtl/rlnb_pkg.sv */
package rlnb_pkg;

  localparam int AREAS      = 16;
  localparam int IDX_W      = 4;
  localparam int CW         = 32;
  localparam int SW         = CW - 1;
  localparam int DW         = CW + 2;
  localparam int SQW        = 2 * DW;
  localparam int SUMW       = SQW + 2;

  localparam int OFS_IDX    = 0;
  localparam int OFS_ONLINE = OFS_IDX + IDX_W;
  localparam int OFS_MIN_X  = OFS_ONLINE + 1;
  localparam int OFS_MIN_Y  = OFS_MIN_X + CW;
  localparam int OFS_MIN_Z  = OFS_MIN_Y + CW;
  localparam int OFS_SIZE_X = OFS_MIN_Z + CW;
  localparam int OFS_SIZE_Y = OFS_SIZE_X + SW;
  localparam int OFS_SIZE_Z = OFS_SIZE_Y + SW;
  localparam int OFS_POS_X  = OFS_SIZE_Z + SW;
  localparam int OFS_POS_Y  = OFS_POS_X + CW;
  localparam int OFS_POS_Z  = OFS_POS_Y + CW;
  localparam int IN_BITS    = OFS_POS_Z + CW;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             wr_en;
    logic             query_start;
    logic             issue;
    logic [IDX_W-1:0] rd_idx;
    logic             out_load;
    logic             out_query;
  } rlnb_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } rlnb_sts_t;

endpackage

/* rtl/rlnb_ctrl.sv */
module rlnb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rlnb_pkg::rlnb_sts_t sts,
  output rlnb_pkg::rlnb_cmd_t cmd
);
  import rlnb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             is_query_r, is_query_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    is_query_nxt  = is_query_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.rd_idx    = cnt_r;
    cmd.out_query = is_query_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_QUERY) begin
            cmd.query_start = 1'b1;
            is_query_nxt    = 1'b1;
            cnt_nxt         = '0;
            state_nxt       = S_SCAN;
          end else begin
            cmd.wr_en    = 1'b1;
            is_query_nxt = 1'b0;
            state_nxt    = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (cnt_r == IDX_W'(AREAS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      is_query_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      is_query_r  <= is_query_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/rlnb_dp.sv */
module rlnb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rlnb_pkg::rlnb_cmd_t                 cmd,
  output rlnb_pkg::rlnb_sts_t                 sts,
  input  logic [rlnb_pkg::IDX_W-1:0]          area_index,
  input  logic                                online,
  input  logic signed [rlnb_pkg::CW-1:0]      min_x,
  input  logic signed [rlnb_pkg::CW-1:0]      min_y,
  input  logic signed [rlnb_pkg::CW-1:0]      min_z,
  input  logic [rlnb_pkg::SW-1:0]             size_x,
  input  logic [rlnb_pkg::SW-1:0]             size_y,
  input  logic [rlnb_pkg::SW-1:0]             size_z,
  input  logic signed [rlnb_pkg::CW-1:0]      pos_x,
  input  logic signed [rlnb_pkg::CW-1:0]      pos_y,
  input  logic signed [rlnb_pkg::CW-1:0]      pos_z,
  output logic                                area_found,
  output logic                                inside_box,
  output logic [rlnb_pkg::IDX_W-1:0]          result_index
);
  import rlnb_pkg::*;

  function automatic logic [DW-1:0] half_dist(logic signed [CW-1:0] p,
                                              logic signed [CW-1:0] m,
                                              logic [SW-1:0] s);
    logic signed [CW+2:0] p2;
    logic signed [CW+2:0] m2;
    logic signed [CW+2:0] s2;
    logic signed [CW+2:0] d;
    p2 = (CW+3)'(signed'({p, 1'b0}));
    m2 = (CW+3)'(signed'({m, 1'b0}));
    s2 = (CW+3)'(signed'({1'b0, s}));
    d  = p2 - m2 - s2;
    return d[CW+2] ? DW'(unsigned'(-d)) : DW'(unsigned'(d));
  endfunction

  function automatic logic in_span(logic signed [CW-1:0] p,
                                   logic signed [CW-1:0] m,
                                   logic [SW-1:0] s);
    logic signed [CW:0] hi;
    hi = (CW+1)'(m) + (CW+1)'(signed'({1'b0, s}));
    return (p >= m) && ((CW+1)'(p) <= hi);
  endfunction

  logic signed [CW-1:0] mem_min_x_r [AREAS];
  logic signed [CW-1:0] mem_min_y_r [AREAS];
  logic signed [CW-1:0] mem_min_z_r [AREAS];
  logic [SW-1:0]        mem_size_x_r [AREAS];
  logic [SW-1:0]        mem_size_y_r [AREAS];
  logic [SW-1:0]        mem_size_z_r [AREAS];
  logic [AREAS-1:0]     online_r;

  logic signed [CW-1:0] pos_x_r, pos_y_r, pos_z_r;

  logic signed [CW-1:0] rd_min_x_r, rd_min_y_r, rd_min_z_r;
  logic [SW-1:0]        rd_size_x_r, rd_size_y_r, rd_size_z_r;
  logic                 v0_r, on0_r;
  logic [IDX_W-1:0]     idx0_r;

  logic [DW-1:0]        dx1_r, dy1_r, dz1_r;
  logic                 v1_r, on1_r, in1_r;
  logic [IDX_W-1:0]     idx1_r;

  logic [SQW-1:0]       sx2_r, sy2_r, sz2_r;
  logic                 v2_r, on2_r, in2_r;
  logic [IDX_W-1:0]     idx2_r;

  logic [SUMW-1:0]      sum3_r;
  logic                 v3_r, on3_r, in3_r;
  logic [IDX_W-1:0]     idx3_r;

  logic                 hit_r, near_r;
  logic [IDX_W-1:0]     hit_idx_r, near_idx_r;
  logic [SUMW-1:0]      best_r;

  logic                 found_r, inside_r;
  logic [IDX_W-1:0]     res_idx_r;

  logic                 wr_ok;
  logic                 upd_hit, upd_near;

  assign wr_ok    = cmd.wr_en && (32'(area_index) < AREAS);
  assign upd_hit  = v3_r && on3_r && in3_r && !hit_r;
  assign upd_near = v3_r && on3_r && !in3_r && (!near_r || (sum3_r < best_r));

  assign sts.pipe_busy = v0_r || v1_r || v2_r || v3_r;

  assign area_found   = found_r;
  assign inside_box   = inside_r;
  assign result_index = res_idx_r;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_min_x_r[area_index]  <= min_x;
      mem_min_y_r[area_index]  <= min_y;
      mem_min_z_r[area_index]  <= min_z;
      mem_size_x_r[area_index] <= size_x;
      mem_size_y_r[area_index] <= size_y;
      mem_size_z_r[area_index] <= size_z;
    end
    if (cmd.issue) begin
      rd_min_x_r  <= mem_min_x_r[cmd.rd_idx];
      rd_min_y_r  <= mem_min_y_r[cmd.rd_idx];
      rd_min_z_r  <= mem_min_z_r[cmd.rd_idx];
      rd_size_x_r <= mem_size_x_r[cmd.rd_idx];
      rd_size_y_r <= mem_size_y_r[cmd.rd_idx];
      rd_size_z_r <= mem_size_z_r[cmd.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      pos_x_r <= pos_x;
      pos_y_r <= pos_y;
      pos_z_r <= pos_z;
    end
    on0_r  <= online_r[cmd.rd_idx];
    idx0_r <= cmd.rd_idx;

    dx1_r  <= half_dist(pos_x_r, rd_min_x_r, rd_size_x_r);
    dy1_r  <= half_dist(pos_y_r, rd_min_y_r, rd_size_y_r);
    dz1_r  <= half_dist(pos_z_r, rd_min_z_r, rd_size_z_r);
    in1_r  <= in_span(pos_x_r, rd_min_x_r, rd_size_x_r)
           && in_span(pos_y_r, rd_min_y_r, rd_size_y_r)
           && in_span(pos_z_r, rd_min_z_r, rd_size_z_r);
    on1_r  <= on0_r;
    idx1_r <= idx0_r;

    sx2_r  <= SQW'(dx1_r) * SQW'(dx1_r);
    sy2_r  <= SQW'(dy1_r) * SQW'(dy1_r);
    sz2_r  <= SQW'(dz1_r) * SQW'(dz1_r);
    in2_r  <= in1_r;
    on2_r  <= on1_r;
    idx2_r <= idx1_r;

    sum3_r <= SUMW'(sx2_r) + SUMW'(sy2_r) + SUMW'(sz2_r);
    in3_r  <= in2_r;
    on3_r  <= on2_r;
    idx3_r <= idx2_r;

    if (upd_hit) begin
      hit_idx_r <= idx3_r;
    end
    if (upd_near) begin
      best_r     <= sum3_r;
      near_idx_r <= idx3_r;
    end

    if (cmd.out_load) begin
      found_r  <= cmd.out_query && (hit_r || near_r);
      inside_r <= cmd.out_query && hit_r;
      if (!cmd.out_query) begin
        res_idx_r <= '0;
      end else if (hit_r) begin
        res_idx_r <= hit_idx_r;
      end else if (near_r) begin
        res_idx_r <= near_idx_r;
      end else begin
        res_idx_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r <= '0;
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      hit_r    <= 1'b0;
      near_r   <= 1'b0;
    end else begin
      if (wr_ok) begin
        online_r[area_index] <= online;
      end
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.query_start) begin
        hit_r  <= 1'b0;
        near_r <= 1'b0;
      end else begin
        if (upd_hit) begin
          hit_r <= 1'b1;
        end
        if (upd_near) begin
          near_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/region_lookup_nearest_box_unit.sv */
// Box table lookup: holds 16 axis-aligned boxes (min corner, size, online flag)
// and answers position queries.
// Input channel in_*: in_tuser selects the item kind (write entry or query);
// in_tdata carries the entry fields and the queried position.
// A write item stores one entry and returns a zero result. A query item returns
// the lowest-index online box that contains the position (faces inclusive), or
// else the online box whose center is nearest by squared distance (lowest
// index on ties), or area_found = 0 when no box is online.
// Output channel out_*: one result item per input item, in order.
// Sequence: a write moves from accept to the done state and then loads its
// result. A query reads one table entry per cycle through a four-stage distance
// pipeline (read, difference, square, sum) and a compare-and-keep stage: all 16
// entries are scanned, the pipeline drains, and the result is loaded.
// One item is in work at a time; the next one is accepted once the current
// result is loaded into the output register, even if that result is not yet
// taken. A stalled receiver holds the result in the output register; a
// finished item waits until the register frees, and no input is taken.
// Reset clears all online flags, so the table starts empty; entry contents
// are not cleared.
module region_lookup_nearest_box_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // op
  input  logic                              in_tuser,
  // area_index, online, min_x, min_y, min_z, size_x, size_y, size_z,
  // pos_x, pos_y, pos_z
  input  logic [rlnb_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // area_found, inside_box, result_index
  output logic [rlnb_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import rlnb_pkg::*;

  rlnb_cmd_t        cmd;
  rlnb_sts_t        sts;
  logic             area_found;
  logic             inside_box;
  logic [IDX_W-1:0] result_index;

  rlnb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlnb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .area_index   (in_tdata[OFS_IDX +: IDX_W]),
    .online       (in_tdata[OFS_ONLINE]),
    .min_x        (signed'(in_tdata[OFS_MIN_X +: CW])),
    .min_y        (signed'(in_tdata[OFS_MIN_Y +: CW])),
    .min_z        (signed'(in_tdata[OFS_MIN_Z +: CW])),
    .size_x       (in_tdata[OFS_SIZE_X +: SW]),
    .size_y       (in_tdata[OFS_SIZE_Y +: SW]),
    .size_z       (in_tdata[OFS_SIZE_Z +: SW]),
    .pos_x        (signed'(in_tdata[OFS_POS_X +: CW])),
    .pos_y        (signed'(in_tdata[OFS_POS_Y +: CW])),
    .pos_z        (signed'(in_tdata[OFS_POS_Z +: CW])),
    .area_found   (area_found),
    .inside_box   (inside_box),
    .result_index (result_index)
  );

  assign out_tdata = OUT_DATA_W'({result_index, inside_box, area_found});

endmodule
